// ===== rtl/php_pkg.sv =====
`default_nettype none

package php_pkg;

  localparam int unsigned HashW    = 32;
  localparam int unsigned OffW     = 32;
  localparam int unsigned SlotW    = 10;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgW     = 4;
  localparam int unsigned OpW      = 2;
  localparam int unsigned ActW     = 5;
  localparam int unsigned SDataW   = 56;
  localparam int unsigned MDataW   = 80;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  localparam int unsigned TableAddrBitsDefault = 10;
  localparam int unsigned MinSizeLog2          = 2;

  localparam logic [CfgW-1:0]  TableSizeReset = 4'd10;
  localparam logic [HashW-1:0] TopNibble      = 32'hF000_0000;
  localparam logic [HashW-1:0] MixMulA        = 32'd1812433253;
  localparam logic [HashW-1:0] MixMulB        = 32'd1989869568;
  localparam int unsigned      FoldShift      = 24;
  localparam int unsigned      HiShift        = 16;
  localparam int unsigned      NibbleShift    = 4;

  // register index of table_size_log2
  localparam logic RegTableSize = 1'b0;

  typedef enum logic [OpW-1:0] {
    OP_PATH  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MIX_HI,
    ST_MIX_LO,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_READ_RES
  } state_e;

  // shift in one byte as a signed char, fold the top nibble into bits 4..7
  function automatic logic [HashW-1:0] hash_byte(logic [HashW-1:0] h, logic [ByteW-1:0] b);
    logic [HashW-1:0] add;
    logic [HashW-1:0] sum;
    logic [HashW-1:0] top;
    add = {{(HashW-ByteW){b[ByteW-1]}}, b};
    sum = (h << NibbleShift) + add;
    top = sum & TopNibble;
    return sum ^ top ^ (top >> FoldShift);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/path_hash_probe_table.sv =====
// Path hash probe table.
//
// Input stream: one item per transfer. tuser carries the operation (path byte,
// read slot, clear table), tlast ends a path. A path byte that is not last
// gives no result. On the last byte the hash is finished in the states
// ST_MIX_HI and ST_MIX_LO on a shared 32x32 multiplier, then the table is
// probed linearly, each probed slot by a memory read, then a check; a hash
// that finishes as 1 skips the mix. At most 2^size probes are made, size being
// table_size_log2 clamped to 2..TABLE_ADDR_BITS; a full table gives status 1.
// A read gives its result from a registered memory read. A clear walks all
// 2^TABLE_ADDR_BITS memory rows, one row per cycle, and is not ready meanwhile.
// Reset: control state clears and a clearing pass over all 2^TABLE_ADDR_BITS
// rows empties the table memory; s_axis_tready stays low until it ends. APB
// writes are taken at any time.
// Results go out through an output register. A stalled receiver holds the
// result there; the block accepts further items meanwhile and waits only when
// it has a new result and the register is still full.
// The APB register table_size_log2 (byte address 0) sets the slots in use.

`default_nettype none

module path_hash_probe_table
  import php_pkg::*;
#(
  parameter int unsigned TABLE_ADDR_BITS = TableAddrBitsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata: path_byte[7:0], byte_present[8], entry_offset[40:9], slot_index[50:41]
  input  wire logic [SDataW-1:0]   s_axis_tdata,
  // tuser: op[1:0]
  input  wire logic [OpW-1:0]      s_axis_tuser,
  input  wire logic                s_axis_tlast,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // tdata: hash_value[31:0], slot[41:32], stored_offset[73:42], slot_valid[74],
  //        status[75]
  output logic [MDataW-1:0]        m_axis_tdata,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0]      prdata,
  output logic                     pready
);

  localparam int unsigned Aw    = TABLE_ADDR_BITS;
  localparam int unsigned Depth = 1 << Aw;
  localparam int unsigned MemW  = 1 + HashW + OffW;

  state_e state_q, state_d;

  logic [CfgW-1:0]  size_log2_q;
  logic [HashW-1:0] run_hash_q;
  logic             seen_q;
  logic [Aw-1:0]    clr_cnt_q;
  logic [HashW-1:0] hv_q;
  logic [OffW-1:0]  off_q;
  logic [HashW-1:0] prod_q;
  logic [Aw-1:0]    pos_q;
  logic [Aw-1:0]    home_q;
  logic [Aw-1:0]    count_q;

  logic             out_valid_q;
  logic [HashW-1:0] out_hash_q;
  logic [SlotW-1:0] out_slot_q;
  logic [OffW-1:0]  out_off_q;
  logic             out_sv_q;
  logic             out_status_q;

  logic [MemW-1:0]  mem [Depth];
  logic [MemW-1:0]  rdata_q;

  // input fields
  logic [ByteW-1:0] in_byte;
  logic             in_present;
  logic [OffW-1:0]  in_offset;
  logic [SlotW-1:0] in_slot;
  assign in_byte    = s_axis_tdata[ByteW-1:0];
  assign in_present = s_axis_tdata[ByteW];
  assign in_offset  = s_axis_tdata[ByteW+OffW:ByteW+1];
  assign in_slot    = s_axis_tdata[ByteW+OffW+SlotW:ByteW+OffW+1];

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // probe mask from the saturated size
  logic [ActW-1:0] act_bits;
  logic [Aw-1:0]   mask;
  always_comb begin
    if ({1'b0, size_log2_q} < ActW'(MinSizeLog2)) begin
      act_bits = ActW'(MinSizeLog2);
    end else if ({1'b0, size_log2_q} > ActW'(Aw)) begin
      act_bits = ActW'(Aw);
    end else begin
      act_bits = {1'b0, size_log2_q};
    end
    for (int i = 0; i < Aw; i++) begin
      mask[i] = (ActW'(i) < act_bits);
    end
  end

  // path hash update at accept
  logic [HashW-1:0] hash_new;
  logic             seen_new;
  logic             finish_one;
  assign hash_new   = in_present ? hash_byte(run_hash_q, in_byte) : run_hash_q;
  assign seen_new   = seen_q || in_present;
  assign finish_one = !seen_new || (hash_new == '0);

  logic [SlotW+Aw-1:0] slot_in_wide;
  logic [Aw-1:0]       read_addr;
  assign slot_in_wide = {{Aw{1'b0}}, in_slot};
  assign read_addr    = slot_in_wide[Aw-1:0] & mask;

  // shared multiplier
  logic [HashW-1:0] mul_x, mul_y, mul_res, mix_val;
  assign mul_res = mul_x * mul_y;
  assign mix_val = prod_q - mul_res;

  logic             rd_valid;
  logic             out_free;
  logic             probe_last;
  assign rd_valid   = rdata_q[MemW-1];
  assign out_free   = !out_valid_q || m_axis_tready;
  assign probe_last = (count_q == mask);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == Aw'(Depth - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          priority if (s_axis_tuser == OP_PATH) begin
            if (s_axis_tlast) state_d = finish_one ? ST_PROBE_RD : ST_MIX_HI;
          end else if (s_axis_tuser == OP_READ) begin
            state_d = ST_READ_RES;
          end else if (s_axis_tuser == OP_CLEAR) begin
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_MIX_HI:   state_d = ST_MIX_LO;
      ST_MIX_LO:   state_d = ST_PROBE_RD;
      ST_PROBE_RD: state_d = ST_PROBE_CHK;
      ST_PROBE_CHK: begin
        if (!rd_valid || probe_last) begin
          if (out_free) state_d = ST_IDLE;
        end else begin
          state_d = ST_PROBE_RD;
        end
      end
      ST_READ_RES: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // control outputs
  logic             mem_we, mem_re;
  logic [Aw-1:0]    mem_waddr, mem_raddr;
  logic [MemW-1:0]  mem_wdata;
  logic             out_load;
  logic [HashW-1:0] res_hash;
  logic [Aw-1:0]    res_pos;
  logic [OffW-1:0]  res_off;
  logic             res_sv;
  logic             res_status;

  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = pos_q;
    mem_raddr     = pos_q;
    mem_wdata     = {1'b1, hv_q, off_q};
    out_load      = 1'b0;
    res_hash      = hv_q;
    res_pos       = pos_q;
    res_off       = off_q;
    res_sv        = 1'b1;
    res_status    = 1'b0;
    mul_x         = hv_q;
    mul_y         = MixMulB;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_acc && (s_axis_tuser == OP_READ)) begin
          mem_re    = 1'b1;
          mem_raddr = read_addr;
        end
      end
      ST_MIX_HI: begin
        mul_x = {{HiShift{1'b0}}, hv_q[HashW-1:HiShift]};
        mul_y = MixMulA;
      end
      ST_MIX_LO: begin
        mul_x = hv_q;
        mul_y = MixMulB;
      end
      ST_PROBE_RD: begin
        mem_re = 1'b1;
      end
      ST_PROBE_CHK: begin
        if (!rd_valid) begin
          mem_we   = out_free;
          out_load = out_free;
        end else if (probe_last) begin
          out_load   = out_free;
          res_pos    = home_q;
          res_off    = '0;
          res_sv     = 1'b0;
          res_status = 1'b1;
        end
      end
      ST_READ_RES: begin
        out_load = out_free;
        res_pos  = pos_q;
        if (rd_valid) begin
          res_hash = rdata_q[HashW+OffW-1:OffW];
          res_off  = rdata_q[OffW-1:0];
          res_sv   = 1'b1;
        end else begin
          res_hash = '0;
          res_off  = '0;
          res_sv   = 1'b0;
        end
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  logic [SlotW+Aw-1:0] res_pos_wide;
  assign res_pos_wide = {{SlotW{1'b0}}, res_pos};

  // table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      size_log2_q <= TableSizeReset;
      run_hash_q  <= '0;
      seen_q      <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite && pready && (paddr[ApbAddrW-1] == RegTableSize)) begin
        size_log2_q <= pwdata[CfgW-1:0];
      end
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + Aw'(1);
      end else if (in_acc && (s_axis_tuser == OP_CLEAR)) begin
        clr_cnt_q <= '0;
      end
      if (in_acc && (s_axis_tuser == OP_PATH)) begin
        if (s_axis_tlast) begin
          run_hash_q <= '0;
          seen_q     <= 1'b0;
        end else begin
          run_hash_q <= hash_new;
          seen_q     <= seen_new;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc && (s_axis_tuser == OP_PATH) && s_axis_tlast) begin
      off_q   <= in_offset;
      count_q <= '0;
      if (finish_one) begin
        hv_q   <= HashW'(1);
        pos_q  <= Aw'(1) & mask;
        home_q <= Aw'(1) & mask;
      end else begin
        hv_q <= hash_new;
      end
    end
    if (in_acc && (s_axis_tuser == OP_READ)) begin
      pos_q <= read_addr;
    end
    if (state_q == ST_MIX_HI) begin
      prod_q <= mul_res;
    end
    if (state_q == ST_MIX_LO) begin
      hv_q   <= mix_val;
      pos_q  <= mix_val[Aw-1:0] & mask;
      home_q <= mix_val[Aw-1:0] & mask;
    end
    if ((state_q == ST_PROBE_CHK) && rd_valid && !probe_last) begin
      pos_q   <= (pos_q + Aw'(1)) & mask;
      count_q <= count_q + Aw'(1);
    end
    if (out_load) begin
      out_hash_q   <= res_hash;
      out_slot_q   <= res_pos_wide[SlotW-1:0];
      out_off_q    <= res_off;
      out_sv_q     <= res_sv;
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(MDataW-HashW-SlotW-OffW-2){1'b0}}, out_status_q, out_sv_q,
                          out_off_q, out_slot_q, out_hash_q};

  assign pready = 1'b1;
  assign prdata = (paddr[ApbAddrW-1] == RegTableSize) ?
                  {{(ApbDataW-CfgW){1'b0}}, size_log2_q} : '0;

endmodule

`default_nettype wire

// ===== rtl/php_checker.sv =====
`default_nettype none

module php_checker
  import php_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tvalid,
  input wire logic              s_axis_tready,
  input wire logic [OpW-1:0]    s_axis_tuser,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [MDataW-1:0] m_axis_tdata
);

  localparam int unsigned SvBit     = HashW + SlotW + OffW;
  localparam int unsigned StatusBit = SvBit + 1;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a dropped insert never reports a filled slot
  a_full_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[StatusBit] |-> !m_axis_tdata[SvBit])
    else $error("full status with slot_valid set");

  // an empty slot reads as zero hash and zero offset
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[StatusBit] && !m_axis_tdata[SvBit]
    |-> (m_axis_tdata[HashW-1:0] == '0) && (m_axis_tdata[SvBit-1:HashW+SlotW] == '0))
    else $error("empty slot read returned data");

  // a clear sweeps the memory, so the input side closes right after it
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_CLEAR) |=> !s_axis_tready)
    else $error("ready during clear sweep");

endmodule

bind path_hash_probe_table php_checker u_php_checker (.*);

`default_nettype wire

// ===== test/path_hash_probe_table_tb.sv =====
module path_hash_probe_table_tb;
  import php_pkg::*;

  localparam int unsigned SlotCount = 1 << SlotW;
  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam logic [ApbAddrW-1:0] SizeAddr = {RegTableSize, 2'b00};
  localparam int SettleCycles = 1100;  // longer than a clear walk over all rows
  localparam int LongHold = 300;
  localparam int PhaseItems = 80;
  localparam int PrintLimit = 100;

  typedef struct {
    logic [HashW-1:0] hash_value;
    logic [SlotW-1:0] slot;
    logic [OffW-1:0]  stored_offset;
    logic             slot_valid;
    logic             status;
  } slot_result_t;

  class probe_table_tracker;
    logic [HashW-1:0] path_hash;
    bit               path_seen;
    logic [HashW-1:0] hash_mem[SlotCount];
    logic [OffW-1:0]  offset_mem[SlotCount];
    bit               occupied[SlotCount];
    logic [CfgW-1:0]  size_log2;
    logic [SlotW-1:0] last_slot;
    slot_result_t     pending_results[$];
    int errors, n_insert, n_full, n_read, n_clear, n_checked;

    function new();
      path_hash = '0;
      path_seen = 0;
      size_log2 = TableSizeReset;
      last_slot = '0;
      foreach (occupied[i]) occupied[i] = 0;
    endfunction

    function logic [SlotW-1:0] probe_mask();
      int b;
      b = int'(size_log2);
      if (b < MinSizeLog2) b = MinSizeLog2;
      if (b > SlotW) b = SlotW;
      return SlotW'((1 << b) - 1);
    endfunction

    function logic [HashW-1:0] fold_in(logic [HashW-1:0] h, logic [ByteW-1:0] b);
      logic [HashW-1:0] acc;
      logic [HashW-1:0] top;
      acc = (h << 4) + {{(HashW-ByteW){b[ByteW-1]}}, b};
      top = acc & TopNibble;
      if (top != 0) acc = acc ^ top ^ (top >> 24);
      return acc;
    endfunction

    function logic [HashW-1:0] finish(logic [HashW-1:0] h, bit any);
      logic [HashW-1:0] mixed;
      if (!any || h == 0) return 1;
      mixed = MixMulA * (h >> 16) - MixMulB * h;
      return mixed;
    endfunction

    function void predict_item(logic [OpW-1:0] op_code, logic [ByteW-1:0] pbyte,
                               logic present, logic last, logic [OffW-1:0] offset,
                               logic [SlotW-1:0] idx);
      slot_result_t r;
      logic [SlotW-1:0] mask;
      logic [SlotW-1:0] home;
      logic [SlotW-1:0] pos;
      logic [HashW-1:0] hv;
      bit placed;
      mask = probe_mask();
      case (op_code)
        OP_PATH: begin
          if (present) begin
            path_hash = fold_in(path_hash, pbyte);
            path_seen = 1;
          end
          if (last) begin
            hv = finish(path_hash, path_seen);
            path_hash = '0;
            path_seen = 0;
            home = hv[SlotW-1:0] & mask;
            pos = home;
            placed = 0;
            for (int n = 0; n <= int'(mask) && !placed; n++) begin
              if (!occupied[pos]) begin
                hash_mem[pos] = hv;
                offset_mem[pos] = offset;
                occupied[pos] = 1;
                placed = 1;
              end else begin
                pos = (pos + SlotW'(1)) & mask;
              end
            end
            r.hash_value = hv;
            n_insert++;
            if (placed) begin
              r.slot = pos;
              r.stored_offset = offset;
              r.slot_valid = 1;
              r.status = 0;
              last_slot = pos;
            end else begin
              r.slot = home;
              r.stored_offset = '0;
              r.slot_valid = 0;
              r.status = 1;
              n_full++;
            end
            pending_results.push_back(r);
          end
        end
        OP_READ: begin
          pos = idx & mask;
          r.slot = pos;
          r.status = 0;
          r.slot_valid = occupied[pos];
          r.hash_value = occupied[pos] ? hash_mem[pos] : '0;
          r.stored_offset = occupied[pos] ? offset_mem[pos] : '0;
          pending_results.push_back(r);
          n_read++;
        end
        OP_CLEAR: begin
          foreach (occupied[i]) occupied[i] = 0;
          n_clear++;
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      if (errors < PrintLimit) $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task compare_result(logic [MDataW-1:0] d);
      slot_result_t w;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing expected: %h", d));
        return;
      end
      w = pending_results.pop_front();
      n_checked++;
      if (d[31:0] !== w.hash_value)
        report($sformatf("hash_value got %h want %h", d[31:0], w.hash_value));
      if (d[41:32] !== w.slot)
        report($sformatf("slot got %0d want %0d", d[41:32], w.slot));
      if (d[73:42] !== w.stored_offset)
        report($sformatf("stored_offset got %h want %h", d[73:42], w.stored_offset));
      if (d[74] !== w.slot_valid)
        report($sformatf("slot_valid got %b want %b", d[74], w.slot_valid));
      if (d[75] !== w.status)
        report($sformatf("status got %b want %b", d[75], w.status));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [SDataW-1:0]   s_axis_tdata;
  logic [OpW-1:0]      s_axis_tuser;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [MDataW-1:0]   m_axis_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  probe_table_tracker tracker;
  int pend_gap;
  bit send_burst;
  bit recv_burst;
  int hold_req;
  int stall_left;

  path_hash_probe_table u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stall after each transfer, long hold-off on request
  initial begin
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
        tracker.compare_result(m_axis_tdata);
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        stall_left = recv_burst ? 0 : $urandom_range(0, 7);
      end
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic [OpW-1:0] op_code, logic [ByteW-1:0] pbyte,
                           logic present, logic last, logic [OffW-1:0] offset,
                           logic [SlotW-1:0] idx);
    if (pend_gap > 0) repeat (pend_gap) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, idx, offset, present, pbyte};
    s_axis_tuser  <= op_code;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    tracker.predict_item(op_code, pbyte, present, last, offset, idx);
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    pend_gap = send_burst ? 0 : $urandom_range(0, 7);
    // drop valid now unless the next transfer follows back to back
    if (pend_gap > 0) s_axis_tvalid <= 1'b0;
  endtask

  task automatic send_path(logic [ByteW-1:0] pbyte, logic present, logic last);
    send_item(OP_PATH, pbyte, present, last, $urandom, SlotW'($urandom));
  endtask

  task automatic send_read(logic [SlotW-1:0] idx);
    send_item(OP_READ, ByteW'($urandom), 1'($urandom), 1'($urandom), $urandom, idx);
  endtask

  task automatic send_other(logic [OpW-1:0] op_code);
    send_item(op_code, ByteW'($urandom), 1'($urandom), 1'($urandom), $urandom,
              SlotW'($urandom));
  endtask

  // stop offering, let every result come out, then let a clear walk finish
  task automatic pause_sender();
    if (pend_gap == 0) s_axis_tvalid <= 1'b0;
    pend_gap = 1;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_size(logic [CfgW-1:0] val);
    logic [ApbDataW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SizeAddr;
    pwdata  <= ApbDataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    tracker.size_log2 = val;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== ApbDataW'(val))
      tracker.report($sformatf("table_size_log2 read %h want %h", rd, val));
  endtask

  task automatic run_directed();
    send_path(8'h61, 1'b1, 1'b1);
    send_path(8'h00, 1'b1, 1'b1);      // zero byte hashes to zero, finishes as 1
    send_path(8'hFF, 1'b0, 1'b1);      // empty path, also 1, probes past it
    send_path(8'h41, 1'b0, 1'b0);      // absent byte, not last: nothing happens
    for (int i = 0; i < 8; i++) send_path(8'hFF, 1'b1, i == 7);  // top nibble folds
    send_path(8'h80, 1'b1, 1'b0);
    send_path(8'h7F, 1'b1, 1'b1);
    send_read(10'd1);
    send_read(10'd2);
    send_read(10'd1023);
    send_read(10'd0);
    send_other(OpUnused);
    send_other(OP_CLEAR);
    send_read(10'd1);
    send_path(8'hA5, 1'b1, 1'b0);
    send_other(OP_CLEAR);              // path in flight survives a clear
    send_path(8'h5A, 1'b1, 1'b1);
    send_read(tracker.last_slot);
  endtask

  // smallest table: fill all slots, then overflow it twice
  task automatic fill_until_full();
    for (int i = 0; i < 6; i++) send_path(ByteW'(8'h31 + i), 1'b1, 1'b1);
    for (int i = 0; i < 4; i++) send_read(SlotW'($urandom) & ~SlotW'(3) | SlotW'(i));
  endtask

  task automatic run_random(int target);
    int done;
    int kind;
    int len;
    logic [ByteW-1:0] pbyte;
    logic [SlotW-1:0] mask;
    done = 0;
    while (done < target) begin
      kind = $urandom_range(0, 99);
      mask = tracker.probe_mask();
      if (kind < 55) begin
        len = $urandom_range(0, 6);
        if (len == 0) begin
          send_path(ByteW'($urandom), 1'b0, 1'b1);
          done++;
        end
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0) send_path(ByteW'($urandom), 1'b0, 1'b0);
          pbyte = ($urandom_range(0, 9) == 0) ? '0 : ByteW'($urandom);
          send_path(pbyte, 1'b1, i == len - 1);
          done++;
        end
      end else if (kind < 88) begin
        // half the reads aim at the latest insert, upper index bits random
        if ($urandom_range(0, 1) == 0)
          send_read((SlotW'($urandom) & ~mask) | tracker.last_slot);
        else
          send_read(SlotW'($urandom));
        done++;
      end else if (kind < 92) begin
        send_other(OP_CLEAR);
        done++;
      end else if (kind < 95) begin
        send_other(OpUnused);
      end else begin
        // broken path: bytes with no end, merged into whatever comes next
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) send_path(ByteW'($urandom), 1'b1, 1'b0);
        done += len;
      end
    end
  endtask

  initial begin
    logic [CfgW-1:0] sizes[8];
    sizes = '{4'd2, 4'd0, 4'd3, 4'd15, 4'd1, 4'd7, 4'd4, 4'd10};
    tracker = new();
    pend_gap = 0;
    send_burst = 0;
    recv_burst = 0;
    hold_req = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_PATH;
    s_axis_tlast  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    for (int p = 0; p < 8; p++) begin
      pause_sender();
      write_size(sizes[p]);
      if (p == 0) fill_until_full();
      if (p == 2) begin
        // hold the output long enough for the block to back up its input
        hold_req = LongHold;
        send_burst = 1;
        for (int i = 0; i < 40; i++) send_read(SlotW'($urandom));
        send_burst = 0;
      end
      if (p == 4) begin
        run_random(PhaseItems / 2);
        pause_sender();
        run_random(PhaseItems / 2);
      end else begin
        run_random(PhaseItems);
      end
    end
    pause_sender();
    repeat (100) @(posedge clk_i);

    $display("Covered %0d inserts (%0d into a full table), %0d slot reads, %0d clears",
             tracker.n_insert, tracker.n_full, tracker.n_read, tracker.n_clear);
    $display("across 8 table size settings; %0d results checked, %0d mismatches",
             tracker.n_checked, tracker.errors);
    if (tracker.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
